/* rtl/hsik_pkg.sv */
`timescale 1ns / 1ps
package hsik_pkg;

    localparam int LEG_COUNT = 6;
    localparam int LEG_W     = 3;

    localparam int OPW  = 35;   // multiplier operand width
    localparam int ACCW = 66;   // accumulator width
    localparam int CINW = 33;   // cordic input width
    localparam int ANGW = 26;   // cordic angle width, 1/65536 degree

    typedef enum logic [1:0] {
        MAC_NOP,
        MAC_MUL,
        MAC_ADD,
        MAC_SUB
    } t_mac_op;

    localparam logic signed [ANGW-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [ANGW-1:0] DEG180 = 26'sd11796480;

    localparam logic signed [OPW-1:0]  HORN2_Q8     = 35'sd16256;
    localparam logic signed [21:0]     HOME_Z_Q8    = 22'sd39058;
    localparam logic signed [ACCW-1:0] ROD_HORN_Q16 = 66'sd1408495616;

    localparam logic signed [15:0] BASE_X [LEG_COUNT] =
        '{16'sd3246, 16'sd12114, -16'sd15360, -16'sd15360, 16'sd12114, 16'sd3246};
    localparam logic signed [15:0] BASE_Y [LEG_COUNT] =
        '{16'sd15862, 16'sd10742, -16'sd5120, 16'sd5120, -16'sd10742, -16'sd15862};
    localparam logic signed [15:0] PLAT_X [LEG_COUNT] =
        '{16'sd833, 16'sd10687, -16'sd11520, -16'sd11520, 16'sd10687, 16'sd833};
    localparam logic signed [15:0] PLAT_Y [LEG_COUNT] =
        '{16'sd12821, 16'sd7132, -16'sd5690, 16'sd5690, -16'sd7132, -16'sd12821};
    localparam logic signed [15:0] BETA_C [LEG_COUNT] =
        '{-16'sd14189, 16'sd14189, 16'sd0, 16'sd0, 16'sd14189, -16'sd14189};
    localparam logic signed [15:0] BETA_S [LEG_COUNT] =
        '{16'sd8192, -16'sd8192, -16'sd16384, 16'sd16384, 16'sd8192, -16'sd8192};

    localparam logic [21:0] ATAN_TAB [20] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
        22'd117304,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
        22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
        22'd115,     22'd57,      22'd29,     22'd14,     22'd7
    };

    // round to nearest, halves away from zero
    function automatic logic signed [ACCW-1:0] f_rnd(input logic signed [ACCW-1:0] v,
                                                     input int unsigned sh);
        logic signed [ACCW-1:0] half;
        logic signed [ACCW-1:0] neg;
        half  = $signed(ACCW'(1) << (sh - 1));
        neg   = $signed({{(ACCW-1){1'b0}}, v[ACCW-1]});
        f_rnd = (v + half - neg) >>> sh;
    endfunction

endpackage

/* rtl/hsik_mac.sv */
`timescale 1ns / 1ps
module hsik_mac
    import hsik_pkg::*;
(
    input  logic                   i_clk,
    input  t_mac_op                i_op,
    input  logic signed [OPW-1:0]  i_a,
    input  logic signed [OPW-1:0]  i_b,
    output logic signed [ACCW-1:0] o_acc
);

    logic signed [2*OPW-1:0] w_full;
    logic signed [ACCW-1:0]  w_prod;
    logic signed [ACCW-1:0]  r_acc;

    assign w_full = i_a * i_b;
    assign w_prod = $signed(w_full[ACCW-1:0]);

    always_ff @(posedge i_clk) begin
        case (i_op)
            MAC_MUL: r_acc <= w_prod;
            MAC_ADD: r_acc <= r_acc + w_prod;
            MAC_SUB: r_acc <= r_acc - w_prod;
            default: r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

/* rtl/hsik_sqrt.sv */
`timescale 1ns / 1ps
module hsik_sqrt
    import hsik_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_busy,
    output logic [31:0] o_root
);

    logic [63:0] r_n;
    logic [63:0] r_r;
    logic [4:0]  r_j;
    logic        r_busy;

    logic [63:0] w_bit;
    logic [63:0] w_trial;
    logic [64:0] w_diff;

    assign w_bit   = 64'(1) << {r_j, 1'b0};
    assign w_trial = r_r + w_bit;
    assign w_diff  = {1'b0, r_n} - {1'b0, w_trial};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_j == 5'd0) begin
            r_busy <= 1'b0;
        end
    end

    // one result bit per cycle, radicand bit pairs from the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= i_radicand;
            r_r <= '0;
            r_j <= 5'd31;
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                r_n <= w_diff[63:0];
                r_r <= (r_r >> 1) + w_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_j <= r_j - 5'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_r[31:0];

endmodule

/* rtl/hsik_cordic.sv */
`timescale 1ns / 1ps
module hsik_cordic
    import hsik_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [CINW-1:0] i_y,
    input  logic signed [CINW-1:0] i_x,
    output logic                   o_busy,
    output logic signed [ANGW-1:0] o_angle
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_NORM,
        C_ITER
    } t_cstate;

    t_cstate                r_state;
    logic [CINW-1:0]        r_ax;
    logic [CINW-1:0]        r_ay;
    logic signed [CINW:0]   r_cx;
    logic signed [CINW:0]   r_cy;
    logic signed [ANGW-1:0] r_a;
    logic [4:0]             r_i;
    logic                   r_x_pos;
    logic                   r_y_neg;
    logic signed [ANGW-1:0] r_res;

    logic [CINW-1:0]        w_inx;
    logic [CINW-1:0]        w_iny;
    logic [CINW-1:0]        w_mx;
    logic signed [CINW:0]   w_sx;
    logic signed [CINW:0]   w_sy;
    logic signed [ANGW-1:0] w_step;
    logic signed [ANGW-1:0] w_na;
    logic signed [ANGW-1:0] w_ca;
    logic signed [ANGW-1:0] w_fin;

    function automatic logic signed [CINW:0] f_shr_tz(input logic signed [CINW:0] v,
                                                      input logic [4:0] sh);
        logic signed [CINW:0] bias;
        bias     = v[CINW] ? $signed((CINW+1)'((64'(1) << sh) - 64'(1))) : '0;
        f_shr_tz = (v + bias) >>> sh;
    endfunction

    assign w_inx  = i_x[CINW-1] ? CINW'(-i_x) : CINW'(i_x);
    assign w_iny  = i_y[CINW-1] ? CINW'(-i_y) : CINW'(i_y);
    assign w_mx   = (r_ax > r_ay) ? r_ax : r_ay;
    assign w_sx   = f_shr_tz(r_cx, r_i);
    assign w_sy   = f_shr_tz(r_cy, r_i);
    assign w_step = $signed({{(ANGW-22){1'b0}}, ATAN_TAB[r_i]});
    assign w_na   = r_cy[CINW] ? (r_a - w_step) : (r_a + w_step);

    always_comb begin
        if (w_na < 0) begin
            w_ca = '0;
        end else if (w_na > DEG90) begin
            w_ca = DEG90;
        end else begin
            w_ca = w_na;
        end
        if (r_x_pos) begin
            w_fin = r_y_neg ? -w_ca : w_ca;
        end else begin
            w_fin = r_y_neg ? -(DEG180 - w_ca) : (DEG180 - w_ca);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_ax    <= w_inx;
                        r_ay    <= w_iny;
                        r_x_pos <= !i_x[CINW-1];
                        r_y_neg <= i_y[CINW-1];
                        if (w_inx == '0 && w_iny == '0) begin
                            r_res <= '0;
                        end else begin
                            r_state <= C_NORM;
                        end
                    end
                end
                // bring the larger magnitude into [2^29, 2^30)
                C_NORM: begin
                    if (w_mx[CINW-1:30] != '0) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end else if (w_mx[CINW-1:25] == '0) begin
                        r_ax <= r_ax << 4;
                        r_ay <= r_ay << 4;
                    end else if (!w_mx[29]) begin
                        r_ax <= r_ax << 1;
                        r_ay <= r_ay << 1;
                    end else begin
                        r_cx    <= $signed({1'b0, r_ax});
                        r_cy    <= $signed({1'b0, r_ay});
                        r_a     <= '0;
                        r_i     <= 5'd0;
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (!r_cy[CINW]) begin
                        r_cx <= r_cx + w_sy;
                        r_cy <= r_cy - w_sx;
                    end else begin
                        r_cx <= r_cx - w_sy;
                        r_cy <= r_cy + w_sx;
                    end
                    r_a <= w_na;
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'd19) begin
                        r_res   <= w_fin;
                        r_state <= C_IDLE;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != C_IDLE);
    assign o_angle = r_res;

endmodule

/* rtl/hexapod_servo_inverse_kinematics_core.sv */
`timescale 1ns / 1ps
// Servo angle solver for a six-leg rotary-servo motion platform.
// Input channel (i_valid / o_ready): one pose per beat, translation in
// 1/256 mm and quaternion in Q1.14. Output channel (o_valid / i_ready):
// six servo angles in 1/256 degree plus a per-leg reach fault mask.
// i_cfg_wr_en / i_cfg_wr_data load the symmetric angle clamp; write it
// only while no pose is in flight.
// One pose at a time: o_ready is high only while the block is idle.
// The rotation matrix is built first, then the six legs in turn, all on
// one shared multiply-accumulate, a one-bit-per-cycle square root and a
// one-step-per-cycle CORDIC (20 rotations after normalizing). A reachable
// leg uses the root twice, with its denominator first shifted below 2^31
// for the second, and the CORDIC twice; a leg marked unreachable skips
// the second root and the asin rotation.
// Results are held on the output ports with o_valid high until i_ready;
// a stalled receiver simply holds the block in that state and the next
// pose is not taken until the beat leaves.
// Reset (synchronous, active low) returns to idle, drops o_valid and
// restores the clamp to 90 degrees.
module hexapod_servo_inverse_kinematics_core
    import hsik_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [14:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_move_x,
    input  logic signed [15:0] i_move_y,
    input  logic signed [15:0] i_move_z,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_servo_angle_0,
    output logic signed [15:0] o_servo_angle_1,
    output logic signed [15:0] o_servo_angle_2,
    output logic signed [15:0] o_servo_angle_3,
    output logic signed [15:0] o_servo_angle_4,
    output logic signed [15:0] o_servo_angle_5,
    output logic [5:0]         o_reach_fault
);

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_Q5, ST_Q6, ST_Q7, ST_Q8,
        ST_Q9, ST_Q10, ST_Q11, ST_Q12, ST_Q13, ST_Q14, ST_Q15, ST_Q16,
        ST_L0, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7, ST_L8,
        ST_L9, ST_L10, ST_L11, ST_L12, ST_L13, ST_SQW1, ST_L14, ST_L15,
        ST_L16, ST_SHF, ST_L17, ST_L18, ST_SQW2, ST_CWA, ST_CWB,
        ST_FIN, ST_OUT
    } t_state;

    t_state r_state;

    logic [14:0]        r_angle_limit;
    logic signed [15:0] r_tx, r_ty, r_tz, r_qw, r_qx, r_qy, r_qz;
    logic signed [OPW-1:0] r_m00, r_m01, r_m10, r_m11, r_m20, r_m21;
    logic [LEG_W-1:0]   r_leg;
    logic signed [21:0] r_x, r_y, r_z;
    logic signed [44:0] r_g;
    logic signed [22:0] r_s;
    logic [36:0]        r_d;
    logic [43:0]        r_ag;
    logic signed [ANGW-1:0] r_atz;
    logic signed [ANGW-1:0] r_asin;
    logic signed [15:0] r_angle [LEG_COUNT];
    logic [5:0]         r_fault;

    t_mac_op               w_op;
    logic signed [OPW-1:0] w_a;
    logic signed [OPW-1:0] w_b;
    logic signed [ACCW-1:0] w_acc;
    logic                  w_sq_start;
    logic                  w_sq_busy;
    logic [31:0]           w_sq_root;
    logic                  w_cd_start;
    logic signed [CINW-1:0] w_cd_y;
    logic signed [CINW-1:0] w_cd_x;
    logic                  w_cd_busy;
    logic signed [ANGW-1:0] w_cd_angle;

    logic signed [ANGW:0]  w_diff;
    logic signed [ANGW:0]  w_rdiff;
    logic signed [ANGW:0]  w_lim;
    logic signed [ANGW:0]  w_ang;
    logic                  w_unreach;

    hsik_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_acc (w_acc)
    );

    hsik_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (w_acc[63:0]),
        .o_busy     (w_sq_busy),
        .o_root     (w_sq_root)
    );

    hsik_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cd_start),
        .i_y     (w_cd_y),
        .i_x     (w_cd_x),
        .o_busy  (w_cd_busy),
        .o_angle (w_cd_angle)
    );

    // operand selection for the shared multiplier
    always_comb begin
        w_op       = MAC_NOP;
        w_a        = '0;
        w_b        = '0;
        w_sq_start = 1'b0;
        w_cd_start = 1'b0;
        w_cd_y     = CINW'(r_s);
        w_cd_x     = CINW'(r_z);
        unique case (r_state)
            ST_Q0:  begin w_op = MAC_MUL; w_a = OPW'(r_qw); w_b = OPW'(r_qw); end
            ST_Q1:  begin w_op = MAC_ADD; w_a = OPW'(r_qx); w_b = OPW'(r_qx); end
            ST_Q2:  begin w_op = MAC_SUB; w_a = OPW'(r_qy); w_b = OPW'(r_qy); end
            ST_Q3:  begin w_op = MAC_SUB; w_a = OPW'(r_qz); w_b = OPW'(r_qz); end
            ST_Q4:  begin w_op = MAC_MUL; w_a = OPW'(r_qw); w_b = OPW'(r_qw); end
            ST_Q5:  begin w_op = MAC_SUB; w_a = OPW'(r_qx); w_b = OPW'(r_qx); end
            ST_Q6:  begin w_op = MAC_ADD; w_a = OPW'(r_qy); w_b = OPW'(r_qy); end
            ST_Q7:  begin w_op = MAC_SUB; w_a = OPW'(r_qz); w_b = OPW'(r_qz); end
            ST_Q8:  begin w_op = MAC_MUL; w_a = OPW'(r_qx); w_b = OPW'(r_qy); end
            ST_Q9:  begin w_op = MAC_SUB; w_a = OPW'(r_qw); w_b = OPW'(r_qz); end
            ST_Q10: begin w_op = MAC_MUL; w_a = OPW'(r_qx); w_b = OPW'(r_qy); end
            ST_Q11: begin w_op = MAC_ADD; w_a = OPW'(r_qw); w_b = OPW'(r_qz); end
            ST_Q12: begin w_op = MAC_MUL; w_a = OPW'(r_qx); w_b = OPW'(r_qz); end
            ST_Q13: begin w_op = MAC_SUB; w_a = OPW'(r_qw); w_b = OPW'(r_qy); end
            ST_Q14: begin w_op = MAC_MUL; w_a = OPW'(r_qy); w_b = OPW'(r_qz); end
            ST_Q15: begin w_op = MAC_ADD; w_a = OPW'(r_qw); w_b = OPW'(r_qx); end
            ST_L0:  begin w_op = MAC_MUL; w_a = r_m00; w_b = OPW'(PLAT_X[r_leg]); end
            ST_L1:  begin w_op = MAC_ADD; w_a = r_m01; w_b = OPW'(PLAT_Y[r_leg]); end
            ST_L2:  begin w_op = MAC_MUL; w_a = r_m10; w_b = OPW'(PLAT_X[r_leg]); end
            ST_L3:  begin w_op = MAC_ADD; w_a = r_m11; w_b = OPW'(PLAT_Y[r_leg]); end
            ST_L4:  begin w_op = MAC_MUL; w_a = r_m20; w_b = OPW'(PLAT_X[r_leg]); end
            ST_L5:  begin w_op = MAC_ADD; w_a = r_m21; w_b = OPW'(PLAT_Y[r_leg]); end
            ST_L6:  begin w_op = MAC_MUL; w_a = OPW'(r_x); w_b = OPW'(r_x); end
            ST_L7:  begin w_op = MAC_ADD; w_a = OPW'(r_y); w_b = OPW'(r_y); end
            ST_L8:  begin w_op = MAC_ADD; w_a = OPW'(r_z); w_b = OPW'(r_z); end
            ST_L9:  begin w_op = MAC_MUL; w_a = OPW'(BETA_C[r_leg]); w_b = OPW'(r_x); end
            ST_L10: begin w_op = MAC_ADD; w_a = OPW'(BETA_S[r_leg]); w_b = OPW'(r_y); end
            ST_L11: begin w_op = MAC_MUL; w_a = OPW'(r_z); w_b = OPW'(r_z); end
            ST_L12: begin
                w_op       = MAC_ADD;
                w_a        = OPW'(r_s);
                w_b        = OPW'(r_s);
                w_cd_start = 1'b1;
            end
            ST_L13: w_sq_start = 1'b1;
            ST_L14: begin
                w_op = MAC_MUL;
                w_a  = HORN2_Q8;
                w_b  = $signed({3'b000, w_sq_root});
            end
            ST_L17: begin
                w_op = MAC_MUL;
                w_a  = $signed({3'b000, r_d[31:0] - r_ag[31:0]});
                w_b  = $signed({2'b00, {1'b0, r_d[31:0]} + {1'b0, r_ag[31:0]}});
            end
            ST_L18: w_sq_start = 1'b1;
            ST_CWA: begin
                w_cd_y = r_g[44] ? -$signed({1'b0, r_ag[31:0]}) : $signed({1'b0, r_ag[31:0]});
                w_cd_x = $signed({1'b0, w_sq_root});
                w_cd_start = !w_cd_busy && !r_fault[r_leg];
            end
            default: begin
                w_op = MAC_NOP;
            end
        endcase
    end

    assign w_unreach = (r_d == '0) || (r_ag > 44'(r_d));

    // final angle: round to 1/256 degree, then clamp
    assign w_diff  = (ANGW+1)'(r_asin) - (ANGW+1)'(r_atz);
    assign w_rdiff = (w_diff + (ANGW+1)'(128) - $signed({{ANGW{1'b0}}, w_diff[ANGW]})) >>> 8;
    assign w_lim   = $signed({{(ANGW-14){1'b0}}, r_angle_limit});
    always_comb begin
        if (w_rdiff > w_lim) begin
            w_ang = w_lim;
        end else if (w_rdiff < -w_lim) begin
            w_ang = -w_lim;
        end else begin
            w_ang = w_rdiff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_angle_limit <= 15'd23040;
        end else begin
            if (i_cfg_wr_en) begin
                r_angle_limit <= i_cfg_wr_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_tx    <= i_move_x;
                        r_ty    <= i_move_y;
                        r_tz    <= i_move_z;
                        r_qw    <= i_quat_w;
                        r_qx    <= i_quat_x;
                        r_qy    <= i_quat_y;
                        r_qz    <= i_quat_z;
                        r_fault <= '0;
                        r_state <= ST_Q0;
                    end
                end
                ST_Q0:  r_state <= ST_Q1;
                ST_Q1:  r_state <= ST_Q2;
                ST_Q2:  r_state <= ST_Q3;
                ST_Q3:  r_state <= ST_Q4;
                ST_Q4:  begin r_m00 <= OPW'(w_acc); r_state <= ST_Q5; end
                ST_Q5:  r_state <= ST_Q6;
                ST_Q6:  r_state <= ST_Q7;
                ST_Q7:  r_state <= ST_Q8;
                ST_Q8:  begin r_m11 <= OPW'(w_acc); r_state <= ST_Q9; end
                ST_Q9:  r_state <= ST_Q10;
                ST_Q10: begin r_m01 <= $signed({w_acc[OPW-2:0], 1'b0}); r_state <= ST_Q11; end
                ST_Q11: r_state <= ST_Q12;
                ST_Q12: begin r_m10 <= $signed({w_acc[OPW-2:0], 1'b0}); r_state <= ST_Q13; end
                ST_Q13: r_state <= ST_Q14;
                ST_Q14: begin r_m20 <= $signed({w_acc[OPW-2:0], 1'b0}); r_state <= ST_Q15; end
                ST_Q15: r_state <= ST_Q16;
                ST_Q16: begin
                    r_m21   <= $signed({w_acc[OPW-2:0], 1'b0});
                    r_leg   <= '0;
                    r_state <= ST_L0;
                end
                ST_L0:  r_state <= ST_L1;
                ST_L1:  r_state <= ST_L2;
                ST_L2:  begin
                    r_x <= 22'(r_tx) + 22'(f_rnd(w_acc, 28)) - 22'(BASE_X[r_leg]);
                    r_state <= ST_L3;
                end
                ST_L3:  r_state <= ST_L4;
                ST_L4:  begin
                    r_y <= 22'(r_ty) + 22'(f_rnd(w_acc, 28)) - 22'(BASE_Y[r_leg]);
                    r_state <= ST_L5;
                end
                ST_L5:  r_state <= ST_L6;
                ST_L6:  begin
                    r_z <= 22'(r_tz) + 22'(f_rnd(w_acc, 28)) + HOME_Z_Q8;
                    r_state <= ST_L7;
                end
                ST_L7:  r_state <= ST_L8;
                ST_L8:  r_state <= ST_L9;
                ST_L9:  begin r_g <= 45'(w_acc - ROD_HORN_Q16); r_state <= ST_L10; end
                ST_L10: r_state <= ST_L11;
                ST_L11: begin r_s <= 23'(f_rnd(w_acc, 14)); r_state <= ST_L12; end
                ST_L12: r_state <= ST_L13;
                ST_L13: r_state <= ST_SQW1;
                ST_SQW1: begin
                    if (!w_sq_busy) begin
                        r_state <= ST_L14;
                    end
                end
                ST_L14: r_state <= ST_L15;
                ST_L15: begin
                    r_d     <= w_acc[36:0];
                    r_ag    <= r_g[44] ? 44'(-r_g) : 44'(r_g);
                    r_state <= ST_L16;
                end
                ST_L16: begin
                    if (w_unreach) begin
                        r_fault[r_leg] <= 1'b1;
                        if (r_g > 0) begin
                            r_asin <= DEG90;
                        end else if (r_g < 0) begin
                            r_asin <= -DEG90;
                        end else begin
                            r_asin <= '0;
                        end
                        r_state <= ST_CWA;
                    end else begin
                        r_state <= ST_SHF;
                    end
                end
                // bring the denominator below 2^31
                ST_SHF: begin
                    if (r_d[36:31] != '0) begin
                        r_d  <= r_d >> 1;
                        r_ag <= r_ag >> 1;
                    end else begin
                        r_state <= ST_L17;
                    end
                end
                ST_L17: r_state <= ST_L18;
                ST_L18: r_state <= ST_SQW2;
                ST_SQW2: begin
                    if (!w_sq_busy) begin
                        r_state <= ST_CWA;
                    end
                end
                ST_CWA: begin
                    if (!w_cd_busy) begin
                        r_atz   <= w_cd_angle;
                        r_state <= r_fault[r_leg] ? ST_FIN : ST_CWB;
                    end
                end
                ST_CWB: begin
                    if (!w_cd_busy) begin
                        r_asin  <= w_cd_angle;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_angle[r_leg] <= 16'(w_ang);
                    if (r_leg == LEG_W'(LEG_COUNT - 1)) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_leg   <= r_leg + LEG_W'(1);
                        r_state <= ST_L0;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = (r_state == ST_OUT);
    assign o_servo_angle_0 = r_angle[0];
    assign o_servo_angle_1 = r_angle[1];
    assign o_servo_angle_2 = r_angle[2];
    assign o_servo_angle_3 = r_angle[3];
    assign o_servo_angle_4 = r_angle[4];
    assign o_servo_angle_5 = r_angle[5];
    assign o_reach_fault   = r_fault;

    a_one_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("pose accepted while a result is pending");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_valid)
        else $error("result presented right after accepting a pose");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (17'(o_servo_angle_0) <= $signed({2'b00, r_angle_limit}) &&
                     17'(o_servo_angle_0) >= -$signed({2'b00, r_angle_limit}) &&
                     17'(o_servo_angle_5) <= $signed({2'b00, r_angle_limit}) &&
                     17'(o_servo_angle_5) >= -$signed({2'b00, r_angle_limit})))
        else $error("servo angle outside clamp");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (!w_sq_busy && !w_cd_busy))
        else $error("leg finished while a shared unit is still busy");

endmodule

/* sim/hexapod_servo_inverse_kinematics_core_test.sv */
`timescale 1ns / 1ps
module hexapod_servo_inverse_kinematics_core_test;
    import hsik_pkg::*;

    localparam int  PHASE_COUNT = 5;
    localparam int  RAND_PER_PHASE = 234;
    localparam longint CYCLE_LIMIT = 6000000;

    localparam longint ANG90  = 5898240;
    localparam longint ANG180 = 11796480;
    localparam longint HORN_2H = 16256;
    localparam longint HOME_Z = 39058;
    localparam longint ROD_HORN = 1408495616;

    typedef struct {
        logic signed [15:0] mx, my, mz;
        logic signed [15:0] qw, qx, qy, qz;
    } t_pose;

    typedef struct {
        logic [15:0] angle [LEG_COUNT];
        logic [5:0]  fault;
    } t_servo_set;

    class servo_scoreboard;
        longint    lim;
        int        errors;
        t_servo_set pending_q[$];

        longint jbx[6] = '{3246, 12114, -15360, -15360, 12114, 3246};
        longint jby[6] = '{15862, 10742, -5120, 5120, -10742, -15862};
        longint jpx[6] = '{833, 10687, -11520, -11520, 10687, 833};
        longint jpy[6] = '{12821, 7132, -5690, 5690, -7132, -12821};
        longint hc[6]  = '{-14189, 14189, 0, 0, 14189, -14189};
        longint hs[6]  = '{8192, -8192, -16384, 16384, 8192, -8192};
        longint arc[20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                            29, 14, 7};

        function new();
            lim = 23040;
            errors = 0;
        endfunction

        function longint unsigned umag(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        function longint round_sh(longint v, int sh);
            longint unsigned m;
            m = (umag(v) + (64'd1 << (sh - 1))) >> sh;
            return v < 0 ? -longint'(m) : longint'(m);
        endfunction

        function longint trunc_sh(longint v, int sh);
            longint unsigned m;
            m = umag(v) >> sh;
            return v < 0 ? -longint'(m) : longint'(m);
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // vectoring atan2, 1/65536 degree
        function longint vec_angle(longint y, longint x);
            longint unsigned ay, ax;
            longint cx, cy, nx, a;
            ay = umag(y);
            ax = umag(x);
            a = 0;
            if (ax == 0 && ay == 0) return 0;
            while ((ax > ay ? ax : ay) >= (64'd1 << 30)) begin
                ax >>= 1;
                ay >>= 1;
            end
            while ((ax > ay ? ax : ay) < (64'd1 << 29)) begin
                ax <<= 1;
                ay <<= 1;
            end
            cx = ax;
            cy = ay;
            for (int i = 0; i < 20; i++) begin
                if (cy >= 0) begin
                    nx = cx + trunc_sh(cy, i);
                    cy = cy - trunc_sh(cx, i);
                    a += arc[i];
                end else begin
                    nx = cx - trunc_sh(cy, i);
                    cy = cy + trunc_sh(cx, i);
                    a -= arc[i];
                end
                cx = nx;
            end
            if (a < 0) a = 0;
            if (a > ANG90) a = ANG90;
            if (x >= 0) return y < 0 ? -a : a;
            return y < 0 ? -(ANG180 - a) : (ANG180 - a);
        endfunction

        function t_servo_set solve_pose(t_pose p);
            t_servo_set r;
            longint tx, ty, tz, w, qi, qj, qk;
            longint m00, m01, m10, m11, m20, m21;
            longint x, y, z, g, s, asin_a, ang;
            longint unsigned d, ag, root;
            tx = p.mx; ty = p.my; tz = p.mz;
            w = p.qw; qi = p.qx; qj = p.qy; qk = p.qz;
            m00 = w * w + qi * qi - qj * qj - qk * qk;
            m01 = 2 * (qi * qj - w * qk);
            m10 = 2 * (qi * qj + w * qk);
            m11 = w * w - qi * qi + qj * qj - qk * qk;
            m20 = 2 * (qi * qk - w * qj);
            m21 = 2 * (qj * qk + w * qi);
            r.fault = '0;
            for (int k = 0; k < LEG_COUNT; k++) begin
                x = tx + round_sh(m00 * jpx[k] + m01 * jpy[k], 28) - jbx[k];
                y = ty + round_sh(m10 * jpx[k] + m11 * jpy[k], 28) - jby[k];
                z = tz + round_sh(m20 * jpx[k] + m21 * jpy[k], 28) + HOME_Z;
                g = x * x + y * y + z * z - ROD_HORN;
                s = round_sh(hc[k] * x + hs[k] * y, 14);
                d = HORN_2H * int_sqrt(longint'(z * z) + longint'(s * s));
                ag = umag(g);
                if (d == 0 || ag > d) begin
                    r.fault[k] = 1'b1;
                    asin_a = g > 0 ? ANG90 : (g < 0 ? -ANG90 : 0);
                end else begin
                    while (d >= (64'd1 << 31)) begin
                        d >>= 1;
                        ag >>= 1;
                    end
                    root = int_sqrt((d - ag) * (d + ag));
                    asin_a = vec_angle(g < 0 ? -longint'(ag) : longint'(ag), root);
                end
                ang = round_sh(asin_a - vec_angle(s, z), 8);
                if (ang > lim) ang = lim;
                if (ang < -lim) ang = -lim;
                r.angle[k] = ang[15:0];
            end
            return r;
        endfunction

        function void note_pose(t_pose p);
            pending_q.push_back(solve_pose(p));
        endfunction

        function void check_servo_set(t_servo_set act);
            t_servo_set e;
            if (pending_q.size() == 0) begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            for (int k = 0; k < LEG_COUNT; k++)
                if (act.angle[k] !== e.angle[k]) begin
                    $error("servo_angle_%0d exp %0d act %0d", k,
                           $signed(e.angle[k]), $signed(act.angle[k]));
                    errors++;
                end
            if (act.fault !== e.fault) begin
                $error("reach_fault exp %b act %b", e.fault, act.fault);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_cfg_wr_en, i_valid, i_ready;
    logic [14:0] i_cfg_wr_data;
    logic signed [15:0] i_move_x, i_move_y, i_move_z;
    logic signed [15:0] i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic o_ready, o_valid;
    logic signed [15:0] o_servo_angle_0, o_servo_angle_1, o_servo_angle_2;
    logic signed [15:0] o_servo_angle_3, o_servo_angle_4, o_servo_angle_5;
    logic [5:0] o_reach_fault;

    hexapod_servo_inverse_kinematics_core u_top (.*);

    servo_scoreboard sb = new();
    longint cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 3000);
        end
        mode_left--;
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 1);
            default: i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_servo_set act;
        if (i_rst_n && o_valid && i_ready) begin
            act.angle[0] = o_servo_angle_0;
            act.angle[1] = o_servo_angle_1;
            act.angle[2] = o_servo_angle_2;
            act.angle[3] = o_servo_angle_3;
            act.angle[4] = o_servo_angle_4;
            act.angle[5] = o_servo_angle_5;
            act.fault = o_reach_fault;
            sb.check_servo_set(act);
        end
    end

    task automatic send_pose(t_pose p);
        int gap;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_move_x = p.mx; i_move_y = p.my; i_move_z = p.mz;
        i_quat_w = p.qw; i_quat_x = p.qx; i_quat_y = p.qy; i_quat_z = p.qz;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pose(p);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 1200);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // drop valid before the block goes idle so the last pose is not taken twice
    task automatic write_limit(logic [14:0] v);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.lim = longint'(v);
    endtask

    function automatic t_pose mk(int mx, int my, int mz, int w, int x, int y, int z);
        t_pose p;
        p.mx = 16'(mx); p.my = 16'(my); p.mz = 16'(mz);
        p.qw = 16'(w); p.qx = 16'(x); p.qy = 16'(y); p.qz = 16'(z);
        return p;
    endfunction

    function automatic t_pose rand_pose();
        t_pose p;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            // plausible pose: modest offset, near-unit rotation
            p.mx = 16'(int'($urandom_range(0, 10240)) - 5120);
            p.my = 16'(int'($urandom_range(0, 10240)) - 5120);
            p.mz = 16'(int'($urandom_range(0, 10240)) - 5120);
            p.qw = 16'(16384 - int'($urandom_range(0, 600)));
            p.qx = 16'(int'($urandom_range(0, 4000)) - 2000);
            p.qy = 16'(int'($urandom_range(0, 4000)) - 2000);
            p.qz = 16'(int'($urandom_range(0, 4000)) - 2000);
        end else begin
            p.mx = 16'($urandom); p.my = 16'($urandom); p.mz = 16'($urandom);
            p.qw = 16'($urandom); p.qx = 16'($urandom);
            p.qy = 16'($urandom); p.qz = 16'($urandom);
            if (kind < 85) begin
                p.qw = 16'(int'($urandom_range(0, 32768)) - 16384);
                p.qx = 16'(int'($urandom_range(0, 32768)) - 16384);
                p.qy = 16'(int'($urandom_range(0, 32768)) - 16384);
                p.qz = 16'(int'($urandom_range(0, 32768)) - 16384);
            end
        end
        return p;
    endfunction

    initial begin
        logic [14:0] limits[PHASE_COUNT];
        limits = '{15'd23040, 15'd0, 15'd32767, 15'($urandom_range(1, 23039)), 15'd23040};
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        {i_move_x, i_move_y, i_move_z} = '0;
        {i_quat_w, i_quat_x, i_quat_y, i_quat_z} = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            write_limit(limits[ph]);
            if (ph == 0 || ph == 2) begin
                send_pose(mk(0, 0, 0, 16384, 0, 0, 0));
                send_pose(mk(32767, 0, 0, 16384, 0, 0, 0));
                send_pose(mk(-32768, 0, 0, 16384, 0, 0, 0));
                send_pose(mk(0, 32767, 0, 16384, 0, 0, 0));
                send_pose(mk(0, -32768, 0, 16384, 0, 0, 0));
                send_pose(mk(0, 0, 32767, 16384, 0, 0, 0));
                send_pose(mk(0, 0, -32768, 16384, 0, 0, 0));
                send_pose(mk(2000, -1500, 800, 16384, 0, 0, 0));
                send_pose(mk(0, 0, 0, 0, 0, 0, 0));           // zero quaternion
                send_pose(mk(0, 0, -32768, 0, 0, 0, 0));
                send_pose(mk(0, 0, 0, -16384, 0, 0, 0));
                send_pose(mk(0, 0, 0, 0, 16384, 0, 0));
                send_pose(mk(0, 0, 0, 0, 0, 16384, 0));
                send_pose(mk(0, 0, 0, 0, 0, 0, 16384));
                send_pose(mk(0, 0, 0, 11585, 11585, 0, 0));   // 90 deg roll
                send_pose(mk(0, 0, 0, 16000, 0, 3000, 0));
                send_pose(mk(0, 0, 0, 16000, -3000, 0, 1500));
                send_pose(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
                send_pose(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
                send_pose(mk(0, 0, 0, 32767, 0, 0, 0));       // oversized quaternion
                send_pose(mk(0, 0, 0, 16384, -16384, 16384, -16384));
                send_pose(mk(12000, 0, -9000, 16384, 0, 0, 0));
            end
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_pose(rand_pose());
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
